// ----- hw/rtl/emr_pkg.sv -----
// Package for the element-wise modular reduction core: widths, register indexes, mode codes.
`default_nettype none

package emr_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned MOD_W   = 62;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned CIDX_W  = 2;

  // pipeline depth, stage 1 takes the input, the last stage drives the outputs
  localparam int unsigned NSTAGE  = 7;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MODULUS = 2'd0,
    CFG_MODE    = 2'd1,
    CFG_FACTOR  = 2'd2,
    CFG_SHIFT   = 2'd3
  } cfg_idx_t;

  localparam logic [MODE_W-1:0] MODE_COPY    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_2Q_TO_Q = 3'd1;
  localparam logic [MODE_W-1:0] MODE_4Q_TO_Q = 3'd2;
  localparam logic [MODE_W-1:0] MODE_4Q_TO_2Q = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BARRETT = 3'd4;

  localparam logic [MOD_W-1:0]   MODULUS_RST = 62'd2;
  localparam logic [MODE_W-1:0]  MODE_RST    = MODE_COPY;
  localparam logic [WORD_W-1:0]  FACTOR_RST  = 64'd0;
  localparam logic [SHIFT_W-1:0] SHIFT_RST   = 6'd1;

endpackage

`default_nettype wire

// ----- hw/rtl/eltwise_modular_reduce_core.sv -----
// Top level: seven-stage pipelined modular reduction (copy, conditional subtract, Barrett).
//
//   channel | ports                                                  | flow
//   --------+--------------------------------------------------------+----------------------
//   in      | in_valid, in_stall, in_value, in_last_in               | one word per transfer
//   out     | out_valid, out_stall, out_reduced, out_last_out        | one result per word
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data              | reg write, always ready
//
// Seven register stages; the first loads at the input transfer and the seventh drives the
// outputs. One word per cycle sustained while out_stall stays low.
// The depth is set by the Barrett path: shift, c*factor partial products, sum to t,
// t*q partial products, subtract, then the 2q and q correction stages.
// Each stage holds its word when the stage after it is full and not moving, so bubbles
// close up and in_stall rises only with all stages full and out_stall high.
// rst_n (synchronous) empties the pipeline and loads the register reset values.
`default_nettype none

module eltwise_modular_reduce_core (
  input  wire                             clk,
  input  wire                             rst_n,
  // input channel
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [emr_pkg::WORD_W-1:0]      in_value,
  input  wire                             in_last_in,
  // result channel
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [emr_pkg::WORD_W-1:0]      out_reduced,
  output logic                            out_last_out,
  // configuration channel
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [emr_pkg::CIDX_W-1:0]      cfg_index,
  input  wire  [emr_pkg::WORD_W-1:0]      cfg_data
);

  localparam int unsigned W  = emr_pkg::WORD_W;
  localparam int unsigned H  = emr_pkg::HALF_W;
  localparam int unsigned N  = emr_pkg::NSTAGE;
  localparam int unsigned QH = emr_pkg::MOD_W - emr_pkg::HALF_W;

  // ---------------------------------------------------------------- config
  logic [emr_pkg::MOD_W-1:0]   modulus_r;
  logic [emr_pkg::MODE_W-1:0]  mode_r;
  logic [W-1:0]                factor_r;
  logic [emr_pkg::SHIFT_W-1:0] shift_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= emr_pkg::MODULUS_RST;
      mode_r    <= emr_pkg::MODE_RST;
      factor_r  <= emr_pkg::FACTOR_RST;
      shift_r   <= emr_pkg::SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (emr_pkg::cfg_idx_t'(cfg_index))
        emr_pkg::CFG_MODULUS: modulus_r <= cfg_data[emr_pkg::MOD_W-1:0];
        emr_pkg::CFG_MODE:    mode_r    <= cfg_data[emr_pkg::MODE_W-1:0];
        emr_pkg::CFG_FACTOR:  factor_r  <= cfg_data;
        emr_pkg::CFG_SHIFT:   shift_r   <= cfg_data[emr_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [W-1:0] q;
  logic [W-1:0] q2;
  assign q  = {2'b00, modulus_r};
  assign q2 = {1'b0, modulus_r, 1'b0};

  // ---------------------------------------------------------------- flow control
  logic [N:1] vld_r;
  logic [N:1] rdy;

  always_comb begin
    rdy[N] = !vld_r[N] || !out_stall;
    for (int k = N - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= N; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // word travels up to the subtract stage, last flag along every stage
  logic [W-1:0] x_r    [1:N-3];
  logic         last_r [1:N];

  // ---------------------------------------------------------------- datapath
  logic [W-1:0] c1_r;                                   // stage 1: x >> shift
  logic [W-1:0] ll2_r, lh2_r, hl2_r, hh2_r;             // stage 2: c*factor partials
  logic [W-1:0] t3_r;                                   // stage 3: high64(c*factor)
  logic [W-1:0] p0_4_r;                                 // stage 4: t*q partials
  logic [H+QH-1:0] p1_4_r;
  logic [W-1:0] p2_4_r;
  logic [W-1:0] w5_r;                                   // stage 5: mode-selected word
  logic [W-1:0] w6_r;                                   // stage 6: after 2q step
  logic [W-1:0] w7_r;                                   // stage 7: after q step

  logic [W-1:0] c1_nxt;
  logic [W-1:0] ll2_nxt, lh2_nxt, hl2_nxt, hh2_nxt;
  logic [H+1:0] mid3;
  logic [W-1:0] t3_nxt;
  logic [W-1:0] p0_4_nxt, p2_4_nxt;
  logic [H+QH-1:0] p1_4_nxt;
  logic [H-1:0] cross5;
  logic [W-1:0] tq5, z5, w5_nxt;
  logic         sub2q, subq;
  logic [W-1:0] w6_nxt, w7_nxt;

  always_comb begin
    c1_nxt = in_value >> shift_r;

    ll2_nxt = c1_r[H-1:0] * factor_r[H-1:0];
    lh2_nxt = c1_r[H-1:0] * factor_r[W-1:H];
    hl2_nxt = c1_r[W-1:H] * factor_r[H-1:0];
    hh2_nxt = c1_r[W-1:H] * factor_r[W-1:H];

    mid3   = {2'b00, ll2_r[W-1:H]} + {2'b00, lh2_r[H-1:0]} + {2'b00, hl2_r[H-1:0]};
    t3_nxt = hh2_r + {{H{1'b0}}, lh2_r[W-1:H]} + {{H{1'b0}}, hl2_r[W-1:H]}
           + {{(W-2){1'b0}}, mid3[H+1:H]};

    // low 64 bits of t*q only
    p0_4_nxt = t3_r[H-1:0] * q[H-1:0];
    p1_4_nxt = t3_r[H-1:0] * modulus_r[emr_pkg::MOD_W-1:H];
    p2_4_nxt = t3_r[W-1:H] * q[H-1:0];

    cross5 = p1_4_r[H-1:0] + p2_4_r[H-1:0];
    tq5    = p0_4_r + {cross5, {H{1'b0}}};
    z5     = x_r[N-3] - tq5;
    w5_nxt = (mode_r == emr_pkg::MODE_BARRETT) ? z5 : x_r[N-3];

    sub2q  = (mode_r == emr_pkg::MODE_4Q_TO_Q) || (mode_r == emr_pkg::MODE_4Q_TO_2Q)
          || (mode_r == emr_pkg::MODE_BARRETT);
    w6_nxt = (sub2q && (w5_r >= q2)) ? w5_r - q2 : w5_r;

    subq   = (mode_r == emr_pkg::MODE_2Q_TO_Q) || (mode_r == emr_pkg::MODE_4Q_TO_Q)
          || (mode_r == emr_pkg::MODE_BARRETT);
    w7_nxt = (subq && (w6_r >= q)) ? w6_r - q : w6_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      c1_r      <= c1_nxt;
      x_r[1]    <= in_value;
      last_r[1] <= in_last_in;
    end
    if (rdy[2]) begin
      ll2_r <= ll2_nxt;
      lh2_r <= lh2_nxt;
      hl2_r <= hl2_nxt;
      hh2_r <= hh2_nxt;
    end
    if (rdy[3]) t3_r <= t3_nxt;
    if (rdy[4]) begin
      p0_4_r <= p0_4_nxt;
      p1_4_r <= p1_4_nxt;
      p2_4_r <= p2_4_nxt;
    end
    if (rdy[5]) w5_r <= w5_nxt;
    if (rdy[6]) w6_r <= w6_nxt;
    if (rdy[7]) w7_r <= w7_nxt;
    for (int k = 2; k <= N - 3; k++) begin
      if (rdy[k]) x_r[k] <= x_r[k-1];
    end
    for (int k = 2; k <= N; k++) begin
      if (rdy[k]) last_r[k] <= last_r[k-1];
    end
  end

  assign out_valid    = vld_r[N];
  assign out_reduced  = w7_r;
  assign out_last_out = last_r[N];

  // ---------------------------------------------------------------- assertions
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&vld_r) && out_stall))
    else $error("input stalled while a pipeline stage is free");

  a_hold_stage6: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[N-1] && !rdy[N]) |=> (vld_r[N-1] && $stable(w6_r) && $stable(last_r[N-1])))
    else $error("stage 6 word lost or changed while blocked");

  a_bubble_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[N-1] && !vld_r[N]) |=> vld_r[N])
    else $error("word did not advance into empty output stage");

endmodule

`default_nettype wire

// ----- sim/emr_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the modular reduction core: tracks register writes, predicts, compares.
module emr_result_checker
  import emr_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_stall,
  input  wire  [WORD_W-1:0]  in_value,
  input  wire                in_last_in,
  input  wire                out_valid,
  input  wire                out_stall,
  input  wire  [WORD_W-1:0]  out_reduced,
  input  wire                out_last_out,
  input  wire                cfg_valid,
  input  wire                cfg_ready,
  input  wire  [CIDX_W-1:0]  cfg_index,
  input  wire  [WORD_W-1:0]  cfg_data,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    word_t reduced;
    logic  last;
  } result_t;

  result_t            expected_results[$];
  logic [MOD_W-1:0]   modulus;
  logic [MODE_W-1:0]  mode;
  word_t              factor;
  logic [SHIFT_W-1:0] shift;
  int                 err_count;
  int                 result_no;

  function automatic word_t sub_if_at_least(word_t x, word_t m);
    return (x >= m) ? x - m : x;
  endfunction

  function automatic word_t reduce_mod_q(word_t x);
    word_t               q;
    word_t               q2;
    word_t               t;
    logic [2*WORD_W-1:0] prod;
    q  = word_t'(modulus);
    q2 = q << 1;
    case (mode)
      MODE_2Q_TO_Q:  return sub_if_at_least(x, q);
      MODE_4Q_TO_Q:  return sub_if_at_least(sub_if_at_least(x, q2), q);
      MODE_4Q_TO_2Q: return sub_if_at_least(x, q2);
      MODE_BARRETT: begin
        // quotient estimate is the upper half of (x >> shift) * factor
        prod = {{WORD_W{1'b0}}, x >> shift} * {{WORD_W{1'b0}}, factor};
        t    = prod[2*WORD_W-1:WORD_W];
        return sub_if_at_least(sub_if_at_least(x - t * q, q2), q);
      end
      // copy and the undefined codes pass the word through
      default:       return x;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    if (err_count < 50) $display("%0t ns: result %0d: %s", $time, result_no, what);
    err_count++;
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      modulus = MODULUS_RST;
      mode    = MODE_RST;
      factor  = FACTOR_RST;
      shift   = SHIFT_RST;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MODULUS: modulus = cfg_data[MOD_W-1:0];
          CFG_MODE:    mode    = cfg_data[MODE_W-1:0];
          CFG_FACTOR:  factor  = cfg_data;
          CFG_SHIFT:   shift   = cfg_data[SHIFT_W-1:0];
          default:     ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("transfer with nothing expected, reduced %h", out_reduced));
        end else begin
          want = expected_results.pop_front();
          if (out_reduced !== want.reduced)
            report_mismatch($sformatf("reduced is %h, expected %h", out_reduced, want.reduced));
          if (out_last_out !== want.last)
            report_mismatch($sformatf("last_out is %b, expected %b", out_last_out, want.last));
        end
        result_no++;
      end
      if (in_valid && !in_stall) begin
        want.reduced = reduce_mod_q(in_value);
        want.last    = in_last_in;
        expected_results.push_back(want);
      end
    end
    outstanding <= expected_results.size();
    mismatches  <= err_count;
  end

endmodule

// ----- sim/tb_eltwise_modular_reduce_core.sv -----
`timescale 1ns / 100ps
// Testbench top for the modular reduction core: stimulus, random idling and the verdict.
module tb_eltwise_modular_reduce_core;
  import emr_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 11;
  localparam int STREAM_ITEMS = 1750;
  localparam int MAX_WAIT     = 11;
  localparam int IDLE_LIMIT   = 1000;

  localparam word_t             MOD_MAX  = {{(WORD_W-MOD_W){1'b0}}, {MOD_W{1'b1}}};
  localparam word_t             DIR_Q    = 64'd1000003;
  localparam logic [MODE_W-1:0] MODE_TOP = '1;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [WORD_W-1:0]   in_value     = '0;
  logic                in_last_in   = 1'b0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [WORD_W-1:0]   out_reduced;
  logic                out_last_out;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index    = CFG_MODULUS;
  logic [WORD_W-1:0]   cfg_data     = '0;

  int                  mismatches;
  int                  outstanding;

  // stimulus view of the current setting, used only to shape operands
  word_t               cur_q        = 64'd2;
  logic [MODE_W-1:0]   cur_mode     = MODE_COPY;
  bit                  steady       = 1'b0;
  int                  sent         = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  eltwise_modular_reduce_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_last_in   (in_last_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_reduced  (out_reduced),
    .out_last_out (out_last_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  emr_result_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_last_in   (in_last_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_reduced  (out_reduced),
    .out_last_out (out_last_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  function automatic word_t rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int pick_wait();
    if (steady) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic int bit_width(word_t v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic word_t pick_modulus();
    int    bw;
    word_t top_bit;
    case ($urandom_range(0, 19))
      0:       return 64'd0;
      1:       return 64'd1;
      2:       return 64'd2;
      3:       return MOD_MAX;
      default: begin
        bw      = $urandom_range(2, MOD_W);
        top_bit = 64'd1 << (bw - 1);
        return top_bit | (rand64() & (top_bit - 1));
      end
    endcase
  endfunction

  // mostly operands inside the mode's input range, some near multiples of q, some noise
  function automatic word_t pick_value();
    logic [2*WORD_W-1:0] span;
    logic [2*WORD_W-1:0] r;
    word_t               q;
    int unsigned         sel;
    q   = cur_q;
    sel = $urandom_range(0, 99);
    r   = {rand64(), rand64()};
    case (cur_mode)
      MODE_COPY:                   span = q;
      MODE_2Q_TO_Q:                span = q << 1;
      MODE_4Q_TO_Q, MODE_4Q_TO_2Q: span = q << 2;
      MODE_BARRETT:                span = q * q;
      default:                     span = '0;
    endcase
    if (sel < 15 || span == 0) return rand64();
    if (sel < 35) return word_t'($urandom_range(0, 4)) * q + word_t'($urandom_range(0, 4)) - 64'd2;
    return word_t'(r % span);
  endfunction

  task automatic load_setting(word_t q, logic [MODE_W-1:0] m, word_t f,
                              logic [SHIFT_W-1:0] sh);
    word_t    junk;
    word_t    data [4];
    cfg_idx_t idx [4];
    bit       noisy;
    junk  = rand64();
    // unused upper data bits are sometimes filled with garbage
    noisy = ($urandom_range(0, 3) == 0);
    idx   = '{CFG_MODULUS, CFG_MODE, CFG_FACTOR, CFG_SHIFT};
    data[0] = noisy ? {junk[WORD_W-1:MOD_W], q[MOD_W-1:0]} : word_t'(q[MOD_W-1:0]);
    data[1] = noisy ? {junk[WORD_W-1:MODE_W], m} : word_t'(m);
    data[2] = f;
    data[3] = noisy ? {junk[WORD_W-1:SHIFT_W], sh} : word_t'(sh);
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_q    = word_t'(q[MOD_W-1:0]);
    cur_mode = m;
  endtask

  // Barrett constants that match q: factor = floor(2^(bw+62) / q), shift = bw - 2; random for q < 2
  task automatic load_matched(word_t q, logic [MODE_W-1:0] m);
    int                  bw;
    logic [2*WORD_W-1:0] quot;
    bw = bit_width(q);
    if (bw < 2) begin
      load_setting(q, m, rand64(), SHIFT_W'($urandom_range(0, 63)));
    end else begin
      quot = (128'd1 << (bw + 62)) / {{WORD_W{1'b0}}, q};
      load_setting(q, m, quot[WORD_W-1:0], SHIFT_W'(bw - 2));
    end
  endtask

  task automatic load_phase_setting(int p);
    word_t             q;
    logic [MODE_W-1:0] m;
    case (p)
      0: load_matched(64'd2, MODE_BARRETT);
      1: load_matched(MOD_MAX, MODE_BARRETT);
      2: load_matched(MOD_MAX, MODE_4Q_TO_Q);
      3: load_matched(64'd2, MODE_4Q_TO_2Q);
      4: load_setting(pick_modulus(), MODE_BARRETT, '1, '1);
      5: load_setting(64'd0, MODE_BARRETT, rand64(), '0);
      6: load_matched(64'd1, MODE_2Q_TO_Q);
      default: begin
        q = pick_modulus();
        if ($urandom_range(0, 6) == 0) m = MODE_W'($urandom_range(MODE_BARRETT + 1, MODE_TOP));
        else m = MODE_W'($urandom_range(MODE_COPY, MODE_BARRETT));
        // inconsistent Barrett constants now and then, shift anywhere in 0..63
        if ($urandom_range(0, 6) == 0) load_setting(q, m, rand64(), SHIFT_W'($urandom()));
        else load_matched(q, m);
      end
    endcase
  endtask

  task automatic send_word(word_t v, logic last);
    int gap;
    gap = pick_wait();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_value   <= v;
    in_last_in <= last;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
  endtask

  // result side: after each transfer, stall for a random wait from pick_wait (none while steady)
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
      if (out_valid && !out_stall) hold = pick_wait();
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [MODE_W-1:0] dir_modes [4];
    word_t             dir_vals [5];
    int                phase;
    int                n;
    dir_modes = '{MODE_2Q_TO_Q, MODE_4Q_TO_Q, MODE_4Q_TO_2Q, MODE_BARRETT};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: copy mode passes both word extremes through
    send_word(64'd0, 1'b1);
    send_word({WORD_W{1'b1}}, 1'b0);
    drain();

    // range edges for each reducing mode
    foreach (dir_modes[i]) begin
      load_matched(DIR_Q, dir_modes[i]);
      if (dir_modes[i] == MODE_BARRETT)
        dir_vals = '{64'd0, DIR_Q - 1, DIR_Q, DIR_Q * DIR_Q - 1, {WORD_W{1'b1}}};
      else
        dir_vals = '{64'd0, DIR_Q - 1, DIR_Q, 2 * DIR_Q - 1, 4 * DIR_Q - 1};
      foreach (dir_vals[j]) send_word(dir_vals[j], j[0]);
      drain();
    end

    // undefined mode code passes the word through
    load_matched(DIR_Q, MODE_TOP);
    send_word({WORD_W{1'b1}}, 1'b1);
    drain();

    phase = 0;
    while (sent < STREAM_ITEMS) begin
      load_phase_setting(phase);
      steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 80);
      repeat (n) send_word(pick_value(), 1'($urandom_range(0, 1)));
      drain();
      phase++;
    end
    steady = 1'b0;

    repeat (NSTAGE + 3) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- eltwise_modular_reduce_core.f -----
hw/rtl/emr_pkg.sv
hw/rtl/eltwise_modular_reduce_core.sv
sim/emr_result_checker.sv
sim/tb_eltwise_modular_reduce_core.sv
